/* rtl/core/pbc_pkg.sv */
`default_nettype none
package pbc_pkg;
   localparam int FRAME_LEN_DEF = 64;
   localparam int NUM_PARTS_DEF = 16;
   localparam int STORE_DEPTH   = 1024;
   localparam int ADDR_W        = 10;
   localparam int COEF_W        = 18;
   localparam int SAMP_W        = 24;
   localparam int LEN_W         = 11;
   // 1024 taps of 18 x 24 bit products need 51 bits plus sign
   localparam int ACC_W         = 52;

   localparam logic CMD_COEF   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic REG_FILTER_LENGTH   = 1'b0;
   localparam logic REG_ACCUMULATE_MODE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   function automatic logic signed [SAMP_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(24'sh7FFFFF);
      lo = -ACC_W'(24'sh7FFFFF) - ACC_W'(1);
      if (x > hi) return 24'sh7FFFFF;
      else if (x < lo) return 24'sh800000;
      else return x[SAMP_W-1:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/core/pbc_if.sv */
`default_nettype none
interface pbc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [9:0]  coef_index;
   logic signed [17:0] coef_value;
   logic signed [23:0] sample_in;
   logic signed [23:0] addend;
   modport source (output valid, command, coef_index, coef_value, sample_in, addend,
                   input ready);
   modport sink (input valid, command, coef_index, coef_value, sample_in, addend,
                 output ready);
endinterface

interface pbc_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [23:0] out_sample;
   logic        last_of_frame;
   modport source (output valid, out_sample, last_of_frame, input ready);
   modport sink (input valid, out_sample, last_of_frame, output ready);
endinterface
`default_nettype wire

/* rtl/core/pbc_ram.sv */
`default_nettype none
module pbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* rtl/core/partitioned_block_convolver.sv */
`default_nettype none
// Frame-based FIR convolver.
// req channel: command 0 writes coef_value to tap coef_index; command 1 delivers
// sample_in plus its addend. Every FRAME_LEN-th sample closes a frame and the block
// then returns FRAME_LEN words on rsp, the last flagged by last_of_frame.
// Each output is computed by one shared multiply-accumulate stepping through the
// coefficient and history memories, one tap per cycle, over filter_length taps
// (capped at FRAME_LEN*NUM_PARTS and at STORE_DEPTH), then a pipeline drain.
// req is held off while a frame is computed.
// Coefficient loads and non-final samples only write memory; no computation runs.
// csr port (APB): register 0 at 0x0 filter_length, register 1 at 0x4 accumulate_mode.
// After reset a clearing pass zeroes the coefficient and history RAMs; req is not
// ready until it ends. Each result waits in an output register; if rsp stalls,
// the next result is computed and then held until the waiting word is taken.
module partitioned_block_convolver
   import pbc_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEF,
   parameter int NUM_PARTS = NUM_PARTS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   pbc_req_if.sink      req,
   pbc_rsp_if.source    rsp,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [2:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int TAP_RAW   = FRAME_LEN * NUM_PARTS;
   localparam int TAP_LIMIT = (TAP_RAW > STORE_DEPTH) ? STORE_DEPTH : TAP_RAW;
   localparam int POS_W     = $clog2(FRAME_LEN);

   state_type state_ff, state_in;
   logic [LEN_W-1:0]  flen_ff;
   logic              amode_ff;
   logic [ADDR_W-1:0] wpos_ff, wpos_in;
   logic [POS_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W:0]   clr_ff, clr_in;
   logic [POS_W-1:0]  p_ff, p_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [LEN_W-1:0]  taps_ff, taps_in;
   logic              v1_ff, v1_in, v2_ff, v2_in;
   logic signed [ACC_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [SAMP_W-1:0] out_ff, out_in;
   logic              last_ff, last_in, ovalid_ff, ovalid_in;

   // memory ports
   logic              c_we, h_we, a_we;
   logic [ADDR_W-1:0] c_wa, h_wa, c_ra, h_ra;
   logic [COEF_W-1:0] c_wd, c_rd;
   logic [SAMP_W-1:0] h_wd, h_rd, a_rd;
   logic [POS_W-1:0]  a_wa, a_ra;

   pbc_ram #(.WIDTH(COEF_W), .DEPTH(STORE_DEPTH)) u_coef (
      .clock(clock), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
   pbc_ram #(.WIDTH(SAMP_W), .DEPTH(STORE_DEPTH)) u_hist (
      .clock(clock), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
   pbc_ram #(.WIDTH(SAMP_W), .DEPTH(FRAME_LEN)) u_add (
      .clock(clock), .we(a_we), .waddr(a_wa), .wdata(req.addend), .raddr(a_ra),
      .rdata(a_rd));

   wire csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         REG_FILTER_LENGTH:   csr_prdata = {{(32-LEN_W){1'b0}}, flen_ff};
         REG_ACCUMULATE_MODE: csr_prdata = {31'd0, amode_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff  <= LEN_W'(STORE_DEPTH);
         amode_ff <= 1'b0;
      end else if (csr_wr && csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == REG_FILTER_LENGTH) flen_ff <= csr_pwdata[LEN_W-1:0];
         else amode_ff <= csr_pwdata[0];
      end
   end

   wire req_acc  = req.valid && req.ready;
   wire last_smp = req_acc && req.command == CMD_SAMPLE && fill_ff == POS_W'(FRAME_LEN-1);
   wire out_free = !ovalid_ff || rsp.ready;
   // history position of tap k for frame sample p: wpos - FRAME_LEN + p - k
   wire [ADDR_W-1:0] pos_base = wpos_ff - ADDR_W'(FRAME_LEN) + ADDR_W'(p_ff);
   wire mac_step = (state_ff == ST_MAC) && (k_ff != taps_ff);

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.out_sample = out_ff;
   assign rsp.last_of_frame = last_ff;

   always_comb begin
      logic signed [COEF_W+SAMP_W-1:0] mul;
      logic signed [SAMP_W-1:0] r;
      state_in = state_ff;
      wpos_in = wpos_ff; fill_in = fill_ff; clr_in = clr_ff;
      p_in = p_ff; k_in = k_ff; taps_in = taps_ff;
      v1_in = mac_step; v2_in = v1_ff;
      prod_in = prod_ff; acc_in = acc_ff;
      out_in = out_ff; last_in = last_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      c_we = 1'b0; c_wa = req.coef_index; c_wd = req.coef_value;
      h_we = 1'b0; h_wa = wpos_ff; h_wd = req.sample_in;
      a_we = 1'b0; a_wa = fill_ff; a_ra = p_ff;
      c_ra = k_ff[ADDR_W-1:0];
      h_ra = pos_base - k_ff[ADDR_W-1:0];
      mul = signed'(c_rd) * signed'(h_rd);
      r = '0;
      if (v1_ff) prod_in = ACC_W'(mul);
      if (v2_ff) acc_in = acc_ff + prod_ff;
      case (state_ff)
         ST_CLEAR: begin
            c_we = 1'b1; h_we = 1'b1;
            c_wa = clr_ff[ADDR_W-1:0]; h_wa = clr_ff[ADDR_W-1:0];
            c_wd = '0; h_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (ADDR_W+1)'(STORE_DEPTH-1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req.command == CMD_COEF) c_we = 1'b1;
               else begin
                  h_we = 1'b1; a_we = 1'b1;
                  wpos_in = wpos_ff + 1'b1;
                  fill_in = last_smp ? '0 : fill_ff + 1'b1;
               end
            end
            if (last_smp) begin
               state_in = ST_MAC;
               p_in = '0; k_in = '0; acc_in = '0;
               taps_in = (flen_ff > LEN_W'(TAP_LIMIT)) ? LEN_W'(TAP_LIMIT) : flen_ff;
            end
         end
         ST_MAC: begin
            if (mac_step) k_in = k_ff + 1'b1;
            else state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               r = sat24((acc_ff + ACC_W'(65536)) >>> 17);
               if (amode_ff) r = sat24(ACC_W'(r) + ACC_W'(signed'(a_rd)));
               out_in = r;
               last_in = (p_ff == POS_W'(FRAME_LEN-1));
               ovalid_in = 1'b1;
               acc_in = '0; k_in = '0;
               p_in = p_ff + 1'b1;
               state_in = (p_ff == POS_W'(FRAME_LEN-1)) ? ST_IDLE : ST_MAC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         wpos_ff   <= '0;
         fill_ff   <= '0;
         clr_ff    <= '0;
         p_ff      <= '0;
         k_ff      <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         ovalid_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         wpos_ff   <= wpos_in;
         fill_ff   <= fill_in;
         clr_ff    <= clr_in;
         p_ff      <= p_in;
         k_ff      <= k_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         ovalid_ff <= ovalid_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff <= taps_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && !rsp.ready |=> ovalid_ff && $stable(out_ff))
      else $error("result word changed while stalled");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> !req.ready)
      else $error("input taken during frame computation");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> k_ff <= taps_ff)
      else $error("tap counter past length");
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      last_smp |=> state_ff == ST_MAC && fill_ff == '0)
      else $error("frame did not start");
endmodule
`default_nettype wire
